// ===== src/pib_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pib_pkg;

	localparam int TICK_W    = 32;
	localparam int LEN_W     = 17;
	localparam int CNT_W     = 16;
	localparam int MAX_FILL  = 62;
	localparam int FILL_W    = 6;
	localparam int DIV_STEPS = 32;
	localparam int STEP_W    = 5;
	localparam int OUT_W     = TICK_W + CNT_W;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(60);
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture the accepted tick
		logic div_step;   // one restoring divide step
		logic slot_calc;  // slot = tick - remainder
		logic decide;     // update interval state
		logic emit;       // load one record into the output register
	} pib_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic close;      // decision needs records
		logic more;       // another fill record follows the current one
		logic out_free;   // output register can take a record
	} pib_stat_t;

endpackage

`default_nettype wire

// ===== src/pib_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pib_ctrl
	import pib_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire pib_stat_t stat,
	output pib_cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV    = 3'd1;
	localparam logic [2:0] ST_SLOT   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0]        state_q;
	logic [STEP_W-1:0] step_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && s_tvalid;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.slot_calc = (state_q == ST_SLOT);
		cmd.decide    = (state_q == ST_DECIDE);
		cmd.emit      = (state_q == ST_EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1))
						state_q <= ST_SLOT;
				end
				ST_SLOT: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= stat.close ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (stat.out_free && !stat.more)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/pib_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pib_dp
	import pib_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [LEN_W-1:0]  cfg_wdata,
	input  wire logic [TICK_W-1:0] s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata,
	output logic                   m_tlast,
	output logic                   m_tuser,
	input  wire pib_cmd_t          cmd,
	output pib_stat_t              stat
);

	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  len_eff;

	logic [TICK_W-1:0] tick_q;
	logic [TICK_W-1:0] shift_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W:0]    trial;
	logic [TICK_W-1:0] slot_q;

	logic [TICK_W-1:0] open_q;
	logic [TICK_W-1:0] closed_q;
	logic [CNT_W-1:0]  count_q;
	logic              open_valid_q;
	logic              closed_valid_q;

	logic [TICK_W-1:0] rec_start_q;
	logic [CNT_W-1:0]  rec_count_q;
	logic [TICK_W:0]   next_q;
	logic [FILL_W-1:0] fill_q;
	logic              next_before_slot;

	logic              out_valid_q;
	logic [TICK_W-1:0] out_start_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_last_q;
	logic              out_trunc_q;

	// a length of zero behaves as one
	assign len_eff = (len_q == '0) ? LEN_W'(1) : len_q;
	assign trial   = {rem_q, shift_q[TICK_W-1]};

	assign next_before_slot = next_q < {1'b0, slot_q};

	assign stat.close = open_valid_q && (slot_q != open_q)
		&& !(closed_valid_q && (open_q == closed_q));
	assign stat.more     = next_before_slot && (fill_q < FILL_W'(MAX_FILL));
	assign stat.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_count_q, out_start_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			len_q <= LEN_RESET;
		else if (cfg_we)
			len_q <= cfg_wdata;
	end

	// restoring divide, remainder only
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tick_q  <= s_tdata;
			shift_q <= s_tdata;
			rem_q   <= '0;
		end else if (cmd.div_step) begin
			shift_q <= {shift_q[TICK_W-2:0], 1'b0};
			if (trial >= {1'b0, len_eff})
				rem_q <= LEN_W'(trial - {1'b0, len_eff});
			else
				rem_q <= trial[LEN_W-1:0];
		end
		if (cmd.slot_calc)
			slot_q <= tick_q - TICK_W'(rem_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_valid_q   <= 1'b0;
			closed_valid_q <= 1'b0;
		end else if (cmd.decide) begin
			if (!open_valid_q)
				open_valid_q <= 1'b1;
			else if (stat.close)
				closed_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			if (!open_valid_q) begin
				open_q  <= slot_q;
				count_q <= CNT_W'(1);
			end else if (slot_q == open_q) begin
				if (count_q != CNT_MAX)
					count_q <= count_q + CNT_W'(1);
			end else if (stat.close) begin
				closed_q    <= open_q;
				rec_start_q <= open_q;
				rec_count_q <= count_q;
				next_q      <= {1'b0, open_q} + (TICK_W + 1)'(len_eff);
				fill_q      <= '0;
				open_q      <= slot_q;
				count_q     <= CNT_W'(1);
			end
		end else if (cmd.emit && stat.more) begin
			rec_start_q <= next_q[TICK_W-1:0];
			rec_count_q <= '0;
			next_q      <= next_q + (TICK_W + 1)'(len_eff);
			fill_q      <= fill_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_start_q <= rec_start_q;
			out_count_q <= rec_count_q;
			out_last_q  <= !stat.more;
			out_trunc_q <= !stat.more && next_before_slot;
		end
	end

endmodule

`default_nettype wire

// ===== src/pulse_interval_binner.sv =====
// throughput: a pulse is taken only once the previous one has gone through the 32-step
//   restoring divide, slot, decide and, when an interval closes, emit; a pulse gives 0 to 63
//   records, out of the datapath at one record per cycle while the output register can take one
// reset: arst_n clears the open and closed interval flags and the output valid,
//   and sets interval_length to 60
`timescale 1ns / 1ps
`default_nettype none

module pulse_interval_binner
	import pib_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// interval_length register
	input  wire logic              cfg_we,
	input  wire logic [LEN_W-1:0]  cfg_wdata,
	// pulse input
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [TICK_W-1:0] s_tdata,   // [31:0] tick_seconds
	// interval records
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata,   // [31:0] interval_start, [47:32] pulse_count
	output logic                   m_tlast,   // last_of_run
	output logic                   m_tuser    // [0] fill_truncated
);

	pib_cmd_t  cmd;
	pib_stat_t stat;

	// controller: idle, divide, slot, decide, emit
	// an input transfer is taken only in idle; the output register keeps the
	// last record of a run so the next pulse can be accepted meanwhile
	pib_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: remainder divider, interval state, fill stepper, output register
	// slot = tick - (tick mod length), so no multiplier is needed
	pib_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

// ===== src/pib_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pib_checker
	import pib_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_tvalid,
	input wire logic              s_tready,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [OUT_W-1:0]  m_tdata,
	input wire logic              m_tlast,
	input wire logic              m_tuser
);

	// a stalled record holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("record changed while stalled");

	// truncation is only flagged on the last record
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("truncation flag without last");

	// truncation only happens on a fill record
	a_trunc_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[OUT_W-1:TICK_W] == '0)
		else $error("truncation flag on a counted record");

	// one pulse at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transfer");

endmodule

bind pulse_interval_binner pib_checker u_chk (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import pib_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int STALL_LIMIT  = 4000;  // cycles with no transfer before giving up
	localparam int HOLD_CYCLES  = 500;   // long receiver hold-off
	localparam int SETTLE       = 80;    // lets a last pulse finish its divide, slot and decide steps
	localparam int PHASE_ITEMS  = 18;
	localparam int NUM_PHASES   = 8;

	// one interval record as it leaves the block
	typedef struct {
		bit [TICK_W-1:0] start;
		bit [CNT_W-1:0]  count;
		bit              last;
		bit              trunc;
	} interval_rec_t;

	// predicts interval records from accepted pulses and checks the block output
	class interval_scoreboard;
		bit [LEN_W-1:0]  len_reg;
		bit [TICK_W-1:0] open_start;
		bit [TICK_W-1:0] closed_start;
		bit [CNT_W-1:0]  run_count;
		bit              open_ok;
		bit              closed_ok;
		interval_rec_t   expected_records[$];
		int              errors;

		function new();
			len_reg      = LEN_RESET;
			open_start   = '0;
			closed_start = '0;
			run_count    = '0;
			open_ok      = 1'b0;
			closed_ok    = 1'b0;
			errors       = 0;
		endfunction

		function void set_length(bit [LEN_W-1:0] value);
			len_reg = value;
		endfunction

		function int outstanding();
			return expected_records.size();
		endfunction

		function void note_pulse(bit [TICK_W-1:0] tick);
			bit [TICK_W-1:0] len;
			bit [TICK_W-1:0] slot;
			bit [TICK_W:0]   nxt;
			int              filled;
			bit              have;
			interval_rec_t   rec;

			len    = (len_reg == '0) ? TICK_W'(1) : TICK_W'(len_reg);
			slot   = (tick / len) * len;
			filled = 0;
			have   = 1'b0;

			// first pulse after reset only opens an interval
			if (!open_ok) begin
				open_start = slot;
				run_count  = CNT_W'(1);
				open_ok    = 1'b1;
				return;
			end
			if (slot == open_start) begin
				if (run_count != CNT_MAX)
					run_count++;
				return;
			end
			if (closed_ok && open_start == closed_start)
				return;

			if (run_count != '0) begin
				rec          = '{open_start, run_count, 1'b0, 1'b0};
				have         = 1'b1;
				closed_start = open_start;
				closed_ok    = 1'b1;
			end
			// zero records between the two intervals, never wrapping past the top
			nxt = {1'b0, open_start} + len;
			while (nxt < {1'b0, slot} && filled < MAX_FILL) begin
				if (have)
					expected_records.push_back(rec);
				rec    = '{nxt[TICK_W-1:0], '0, 1'b0, 1'b0};
				have   = 1'b1;
				filled++;
				nxt    = nxt + len;
			end
			if (have) begin
				rec.last  = 1'b1;
				rec.trunc = (nxt < {1'b0, slot});
				expected_records.push_back(rec);
			end
			run_count  = CNT_W'(1);
			open_start = slot;
		endfunction

		function void check_record(bit [TICK_W-1:0] start, bit [CNT_W-1:0] count,
			bit last, bit trunc);
			interval_rec_t want;

			if (expected_records.size() == 0) begin
				errors++;
				$display("%0t: unexpected record start=%0d count=%0d last=%0b trunc=%0b",
					$time, start, count, last, trunc);
				return;
			end
			want = expected_records.pop_front();
			if (want.start != start) begin
				errors++;
				$display("%0t: interval_start expected %0d actual %0d",
					$time, want.start, start);
			end
			if (want.count != count) begin
				errors++;
				$display("%0t: pulse_count expected %0d actual %0d (start %0d)",
					$time, want.count, count, want.start);
			end
			if (want.last != last) begin
				errors++;
				$display("%0t: last_of_run expected %0b actual %0b (start %0d)",
					$time, want.last, last, want.start);
			end
			if (want.trunc != trunc) begin
				errors++;
				$display("%0t: fill_truncated expected %0b actual %0b (start %0d)",
					$time, want.trunc, trunc, want.start);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [LEN_W-1:0]  cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [TICK_W-1:0] s_tdata;   // [31:0] tick_seconds
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;   // [31:0] interval_start, [47:32] pulse_count
	logic              m_tlast;   // last_of_run
	logic              m_tuser;   // [0] fill_truncated

	interval_scoreboard sb = new();

	int              tx_idle_pct  = 22;
	int              rx_idle_pct  = 68;
	bit              hold_request = 1'b0;
	bit [TICK_W-1:0] prev_tick    = '0;

	pulse_interval_binner DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// offer one pulse, note it on the transfer, then maybe go quiet for a while
	task automatic send_pulse(input bit [TICK_W-1:0] tick);
		s_tvalid <= 1'b1;
		s_tdata  <= tick;
		do @(posedge clk); while (!s_tready);
		sb.note_pulse(tick);
		prev_tick = tick;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			repeat ($urandom_range(1, 60)) @(posedge clk);
		end
	endtask

	// register write only once the block has drained and gone quiet
	task automatic write_interval_len(input bit [LEN_W-1:0] value);
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_length(value);
		cfg_we    <= 1'b0;
		cfg_wdata <= LEN_W'($urandom);
	endtask

	// mostly plausible meter time: same interval, a few intervals on, long gaps,
	// with some steps back, jumps anywhere and ticks close to the top of time
	function automatic bit [TICK_W-1:0] next_tick(bit [TICK_W-1:0] cur,
		bit [LEN_W-1:0] len_cfg);
		longint l;
		longint c;
		longint t;
		int     pick;

		l    = (len_cfg == '0) ? 1 : len_cfg;
		c    = cur;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			t = c + $urandom_range(0, 3);
		else if (pick < 60)
			t = c + l * $urandom_range(1, 4) + $urandom_range(0, int'(l - 1));
		else if (pick < 72)
			t = c + l * $urandom_range(5, 90);
		else if (pick < 82)
			t = c - l * $urandom_range(1, 8);
		else if (pick < 92)
			t = $urandom;
		else
			t = 64'hFFFF_FFFF - l * $urandom_range(0, 3) - $urandom_range(0, 9);
		if (t < 0)
			t = $urandom_range(0, 99);
		else if (t > 64'hFFFF_FFFF)
			t = 64'hFFFF_FFFF - $urandom_range(0, 9);
		return t[TICK_W-1:0];
	endfunction

	// receiver: checks every record transfer, stalls at random or on request
	initial begin
		int hold_left;

		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_record(m_tdata[TICK_W-1:0], m_tdata[OUT_W-1:TICK_W],
					m_tlast, m_tuser);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
				m_tready     <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// watchdog: gives up after a long run of cycles with no transfer on either side
	initial begin
		int stall;

		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall = 0;
			else
				stall++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		bit [LEN_W-1:0]  phase_len [NUM_PHASES];
		bit [TICK_W-1:0] cur;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, reset length of 60
		send_pulse(32'd0);              // first pulse only opens
		send_pulse(32'd59);             // same interval
		send_pulse(32'd60);             // neighbor, no fill
		send_pulse(32'd200);            // one fill record
		send_pulse(32'd100);            // time going backwards
		send_pulse(32'd4205);           // fill past the cap
		send_pulse(32'hFFFF_FFFF);      // top of time
		send_pulse(32'hFFFF_FFFE);
		send_pulse(32'd1000);           // back down, next start would wrap

		// zero length acts as one, changed while an interval is open
		write_interval_len('0);
		send_pulse(32'd963);
		send_pulse(32'd963);
		send_pulse(32'd964);

		// oversized length, all ones
		write_interval_len('1);
		send_pulse(32'h8000_0000);
		send_pulse(32'h7FFF_FFFF);
		send_pulse(32'd393213);

		write_interval_len(LEN_W'(1));
		send_pulse(32'd5);
		send_pulse(32'd6);
		send_pulse(32'd8);

		// a day per interval: exactly the cap, then one past it
		write_interval_len(LEN_W'(86400));
		send_pulse(32'd86399);
		send_pulse(32'd5443201);        // 62 skipped intervals
		send_pulse(32'd5529600);
		send_pulse(32'd11059200);       // 63 skipped intervals

		// random phases, each under its own length and pacing
		phase_len = '{LEN_W'(60), LEN_W'(1), LEN_W'(600), LEN_W'(86400), LEN_W'(0),
			LEN_W'(131071), LEN_W'(7), LEN_W'(60)};
		phase_len[NUM_PHASES-1] = LEN_W'($urandom_range(2, 131071));
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_interval_len(phase_len[ph]);
			if (ph < 3) begin
				tx_idle_pct = 22;
				rx_idle_pct = 68;
			end else if (ph < 6) begin
				tx_idle_pct = 68;
				rx_idle_pct = 22;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			// back up the output while pulses keep coming
			if (ph == 6)
				hold_request = 1'b1;
			cur = prev_tick;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				cur = next_tick(cur, phase_len[ph]);
				send_pulse(cur);
			end
		end

		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
